// ----- rtl/bdmj_pkg.sv -----
// Shared types and constants for the birth-death mutation jump-step block.
// Used by bdmj_event, the top level and the port checker. It depends on nothing else.
package bdmj_pkg;

    // Configuration register indexes, in the order of the register list.
    typedef enum logic [3:0] {
        REG_INIT_WILD  = 4'd0,
        REG_INIT_M1    = 4'd1,
        REG_INIT_M2    = 4'd2,
        REG_INIT_M12   = 4'd3,
        REG_BIRTH_RATE = 4'd4,
        REG_DEATH_RATE = 4'd5,
        REG_MUT_PROB   = 4'd6,
        REG_STEP_LIMIT = 4'd7
    } bdmj_reg_t;

    typedef enum logic {
        FUNC_STEP   = 1'b0,
        FUNC_RELOAD = 1'b1
    } bdmj_func_t;

    typedef enum logic [1:0] {
        TYPE_WILD = 2'd0,
        TYPE_M1   = 2'd1,
        TYPE_M2   = 2'd2,
        TYPE_M12  = 2'd3
    } bdmj_type_t;

    localparam int THR_BITS  = 33;
    localparam int WORD_BITS = 16;

    // Rate settings and offspring band thresholds (Q1.32) held by the top level.
    typedef struct packed {
        logic [WORD_BITS-1:0] birth_rate;
        logic [WORD_BITS-1:0] death_rate;
        logic [WORD_BITS-1:0] step_limit;
        logic [THR_BITS-1:0]  thr0;
        logic [THR_BITS-1:0]  thr1;
        logic [THR_BITS-1:0]  thr2;
    } bdmj_rates_t;

    // Offspring type for a given parent type and mutation band.
    function automatic bdmj_type_t offspring_type(input bdmj_type_t parent,
                                                  input logic [1:0] band);
        bdmj_type_t child;
        child = TYPE_WILD;
        unique case (parent)
            TYPE_WILD: begin
                unique case (band)
                    2'd0:    child = TYPE_WILD;
                    2'd1:    child = TYPE_M1;
                    2'd2:    child = TYPE_M2;
                    default: child = TYPE_M12;
                endcase
            end
            TYPE_M1: begin
                unique case (band)
                    2'd0:    child = TYPE_M1;
                    2'd1:    child = TYPE_M12;
                    2'd2:    child = TYPE_WILD;
                    default: child = TYPE_M2;
                endcase
            end
            TYPE_M2: begin
                unique case (band)
                    2'd0:    child = TYPE_M2;
                    2'd1:    child = TYPE_M12;
                    2'd2:    child = TYPE_WILD;
                    default: child = TYPE_M1;
                endcase
            end
            default: begin
                unique case (band)
                    2'd0:    child = TYPE_M12;
                    2'd1:    child = TYPE_M1;
                    2'd2:    child = TYPE_M2;
                    default: child = TYPE_WILD;
                endcase
            end
        endcase
        return child;
    endfunction

endpackage

// ----- rtl/bdmj_event.sv -----
// Event logic for one word: birth or death choice, parent and offspring choice,
// and the new counts and step number. Depends on bdmj_pkg.
module bdmj_event #(
    parameter int COUNT_BITS = 16
) (
    input  logic                   func,
    input  logic [15:0]            u_event,
    input  logic [15:0]            u_parent,
    input  logic [15:0]            u_offspring,
    input  bdmj_pkg::bdmj_rates_t  rates,
    input  logic [15:0]            initial_count [4],
    input  logic [COUNT_BITS-1:0]  count_cur [4],
    input  logic [15:0]            step_cur,
    output logic [COUNT_BITS-1:0]  count_new [4],
    output logic [15:0]            step_new,
    output logic [15:0]            step_index,
    output logic                   done_res
);
    import bdmj_pkg::*;

    localparam int SUM_BITS  = COUNT_BITS + 2;
    localparam int PICK_BITS = SUM_BITS + 16;
    localparam int WIDE      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [SUM_BITS-1:0]  cum [4];
    logic [PICK_BITS-1:0] pick_lhs;
    logic [16:0]          rate_sum;
    logic [32:0]          event_lhs;
    logic                 birth;
    logic [32:0]          band_val;
    logic [1:0]           band;
    bdmj_type_t           parent;
    bdmj_type_t           child;

    assign cum[0] = SUM_BITS'(count_cur[0]);
    assign cum[1] = cum[0] + SUM_BITS'(count_cur[1]);
    assign cum[2] = cum[1] + SUM_BITS'(count_cur[2]);
    assign cum[3] = cum[2] + SUM_BITS'(count_cur[3]);

    assign pick_lhs = PICK_BITS'(u_parent) * PICK_BITS'(cum[3]);

    always_comb begin
        priority if (pick_lhs < {cum[0], 16'h0000}) begin
            parent = TYPE_WILD;
        end else if (pick_lhs < {cum[1], 16'h0000}) begin
            parent = TYPE_M1;
        end else if (pick_lhs < {cum[2], 16'h0000}) begin
            parent = TYPE_M2;
        end else begin
            parent = TYPE_M12;
        end
    end

    assign rate_sum  = {1'b0, rates.birth_rate} + {1'b0, rates.death_rate};
    assign event_lhs = 33'(u_event) * 33'(rate_sum);
    assign birth     = event_lhs < {1'b0, rates.birth_rate, 16'h0000};

    assign band_val = {1'b0, u_offspring, 16'h0000};

    always_comb begin
        priority if (band_val < rates.thr0) begin
            band = 2'd0;
        end else if (band_val < rates.thr1) begin
            band = 2'd1;
        end else if (band_val < rates.thr2) begin
            band = 2'd2;
        end else begin
            band = 2'd3;
        end
    end

    assign child = offspring_type(parent, band);

    always_comb begin
        count_new  = count_cur;
        step_new   = step_cur;
        step_index = step_cur;
        done_res   = 1'b0;
        if (func == FUNC_RELOAD) begin
            for (int k = 0; k < 4; k++) begin
                if (WIDE'(initial_count[k]) > WIDE'(COUNT_MAX)) begin
                    count_new[k] = COUNT_MAX;
                end else begin
                    count_new[k] = COUNT_BITS'(initial_count[k]);
                end
            end
            step_new   = 16'd1;
            step_index = 16'd0;
        end else if (step_cur > rates.step_limit || cum[3] == '0) begin
            done_res   = 1'b1;
            step_index = step_cur - 16'd1;
        end else begin
            if (birth) begin
                if (count_cur[child] != COUNT_MAX) begin
                    count_new[child] = count_cur[child] + COUNT_BITS'(1);
                end
            end else if (count_cur[parent] != '0) begin
                count_new[parent] = count_cur[parent] - COUNT_BITS'(1);
            end
            if (step_cur != 16'hFFFF) begin
                step_new = step_cur + 16'd1;
            end
        end
    end

endmodule

// ----- rtl/birth_death_mutation_jump_step.sv -----
// Top level of the birth-death mutation jump-step block: ports, configuration
// registers, population state and the result register. Depends on bdmj_pkg, bdmj_event.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata (three fractions), s_tuser (func)
//  m_        out        m_tvalid / m_tready  m_tdata (counts, step), m_tuser (done)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word is taken every cycle unless stalled; its result is registered on the next cycle.
// The population counts and step counter are updated at the same edge that takes the word,
// so the following word sees them at once. The output register is the only stall point:
// s_tready is low only while a result waits and m_tready is low.
// Synchronous active-low reset restores the register reset values and the initial counts.
module birth_death_mutation_jump_step #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // u_event, u_parent, u_offspring
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // count_wild, count_m1, count_m2, count_m12, step_index
    output logic [0:0]  m_tuser,   // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bdmj_pkg::*;

    localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [15:0]           init_reg [4];
    logic [15:0]           init_next [4];
    bdmj_rates_t           rates_reg;
    bdmj_rates_t           rates_next;
    logic [COUNT_BITS-1:0] count_reg [4];
    logic [COUNT_BITS-1:0] count_new [4];
    logic [15:0]           step_reg;
    logic [15:0]           step_new;
    logic [15:0]           step_index;
    logic                  done_res;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [79:0]           m_tdata_reg;
    logic [0:0]            m_tuser_reg;
    logic                  s_accept;
    logic [16:0]           mut_a;
    logic [33:0]           mut_sq;
    logic [33:0]           mut_cross;
    logic [15:0]           count_out [4];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Band thresholds are formed when the mutation probability is written.
    assign mut_a     = 17'h10000 - {1'b0, cfg_data};
    assign mut_sq    = 34'(mut_a) * 34'(mut_a);
    assign mut_cross = 34'(mut_a) * 34'(cfg_data);

    always_comb begin
        init_next  = init_reg;
        rates_next = rates_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_INIT_WILD:  init_next[0] = cfg_data;
                REG_INIT_M1:    init_next[1] = cfg_data;
                REG_INIT_M2:    init_next[2] = cfg_data;
                REG_INIT_M12:   init_next[3] = cfg_data;
                REG_BIRTH_RATE: rates_next.birth_rate = cfg_data;
                REG_DEATH_RATE: rates_next.death_rate = cfg_data;
                REG_MUT_PROB: begin
                    rates_next.thr0 = mut_sq[32:0];
                    rates_next.thr1 = mut_sq[32:0] + mut_cross[32:0];
                    rates_next.thr2 = mut_sq[32:0] + {mut_cross[31:0], 1'b0};
                end
                REG_STEP_LIMIT: rates_next.step_limit = cfg_data;
                default: ;
            endcase
        end
    end

    bdmj_event #(
        .COUNT_BITS (COUNT_BITS)
    ) u_event (
        .func          (s_tuser[0]),
        .u_event       (s_tdata[15:0]),
        .u_parent      (s_tdata[31:16]),
        .u_offspring   (s_tdata[47:32]),
        .rates         (rates_reg),
        .initial_count (init_reg),
        .count_cur     (count_reg),
        .step_cur      (step_reg),
        .count_new     (count_new),
        .step_new      (step_new),
        .step_index    (step_index),
        .done_res      (done_res)
    );

    assign m_tvalid_next = s_accept || (m_tvalid_reg && !m_tready);

    always_comb begin
        logic [WIDE-1:0] wide_count;
        for (int k = 0; k < 4; k++) begin
            wide_count   = WIDE'(count_new[k]);
            count_out[k] = wide_count[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg[0]          <= 16'd1;
            init_reg[1]          <= 16'd0;
            init_reg[2]          <= 16'd0;
            init_reg[3]          <= 16'd0;
            rates_reg.birth_rate <= 16'd256;
            rates_reg.death_rate <= 16'd256;
            rates_reg.step_limit <= 16'd10;
            rates_reg.thr0       <= 33'h1_0000_0000;
            rates_reg.thr1       <= 33'h1_0000_0000;
            rates_reg.thr2       <= 33'h1_0000_0000;
            count_reg[0]         <= COUNT_BITS'(1);
            count_reg[1]         <= '0;
            count_reg[2]         <= '0;
            count_reg[3]         <= '0;
            step_reg             <= 16'd1;
            m_tvalid_reg         <= 1'b0;
        end else begin
            init_reg     <= init_next;
            rates_reg    <= rates_next;
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                count_reg <= count_new;
                step_reg  <= step_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {step_index, count_out[3], count_out[2], count_out[1], count_out[0]};
            m_tuser_reg <= done_res;
        end
    end

endmodule

// ----- rtl/bdmj_checker.sv -----
// Port checker for the birth-death mutation jump-step block, bound to its top level.
// Depends on bdmj_pkg for the reload code.
module bdmj_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import bdmj_pkg::*;

    // A stalled result keeps its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Every accepted word leaves a result in the output register on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // A reload reports step zero and is never marked done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == FUNC_RELOAD
        |=> m_tdata[79:64] == 16'd0 && m_tuser[0] == 1'b0)
        else $error("reload result has wrong step or done flag");

    // Input is held back only by a result that is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

endmodule

bind birth_death_mutation_jump_step bdmj_checker u_bdmj_checker (.*);
